[sv/wbps_pkg.sv]
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared constants and types of the wildcard byte pattern scanner.
// ----------------------------------------------------------------------------
package wbps_pkg;

  // Depth of the sliding window, which is also the longest usable signature.
  localparam int unsigned MaxPatternBytes = 16;
  localparam int unsigned WinIdxW = (MaxPatternBytes > 1) ? $clog2(MaxPatternBytes) : 1;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned AddrW    = 32;
  localparam int unsigned LenW     = 5;
  localparam int unsigned CareW    = 16;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 64;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_PATTERN_LOW  = 8'd0,
    REG_PATTERN_HIGH = 8'd1,
    REG_CARE_MASK    = 8'd2,
    REG_PATTERN_LEN  = 8'd3
  } cfg_reg_e;

  // Per-cycle control that every window cell sees.
  typedef struct packed {
    logic shift;  // take the neighbor's byte and valid bit
    logic clear;  // drop the held byte (valid bit goes low)
  } cell_ctrl_t;

endpackage

[sv/wbps_in_if.sv]
// ----------------------------------------------------------------------------
// wbps_in_if
// Byte stream channel into the scanner: one byte with its address and flags.
// ----------------------------------------------------------------------------
interface wbps_in_if;
  logic                          valid;
  logic                          ready;
  logic [wbps_pkg::ByteW-1:0]    data_byte;
  logic [wbps_pkg::AddrW-1:0]    byte_address;
  logic                          region_start;
  logic                          new_search;

  modport source (
    output valid, data_byte, byte_address, region_start, new_search,
    input  ready
  );

  modport sink (
    input  valid, data_byte, byte_address, region_start, new_search,
    output ready
  );
endinterface

[sv/wbps_out_if.sv]
// ----------------------------------------------------------------------------
// wbps_out_if
// Result channel of the scanner: the start address of the first match.
// ----------------------------------------------------------------------------
interface wbps_out_if;
  logic                          valid;
  logic                          ready;
  logic [wbps_pkg::AddrW-1:0]    match_address;

  modport source (
    output valid, match_address,
    input  ready
  );

  modport sink (
    input  valid, match_address,
    output ready
  );
endinterface

[sv/wbps_cell.sv]
// ----------------------------------------------------------------------------
// wbps_cell
// One window slot: holds a byte and its valid bit, passes them on to the next
// slot and compares the incoming byte against its signature byte.
// ----------------------------------------------------------------------------
module wbps_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  wbps_pkg::cell_ctrl_t       ctrl_i,
  input  logic [wbps_pkg::ByteW-1:0] byte_i,
  input  logic                       valid_i,
  input  logic [wbps_pkg::ByteW-1:0] pat_byte_i,
  input  logic                       care_i,
  input  logic                       in_use_i,
  output logic [wbps_pkg::ByteW-1:0] byte_o,
  output logic                       valid_o,
  output logic                       ok_o
);

  logic [wbps_pkg::ByteW-1:0] byte_q, byte_d;
  logic                       valid_q, valid_d;

  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    if (ctrl_i.shift) begin
      valid_d = valid_i;
      byte_d  = byte_i;
    end else if (ctrl_i.clear) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  // The compare looks at the byte that enters this slot in the current transfer.
  assign ok_o    = !in_use_i || !care_i || (byte_i == pat_byte_i);
  assign byte_o  = byte_q;
  assign valid_o = valid_q;

endmodule

[sv/wildcard_byte_pattern_scan.sv]
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scan
// Searches a byte stream for a signature with don't-care positions and reports
// the start address of the first match.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle, sustained, while the result side keeps up.
// Result: a match is visible on the result channel in the cycle after the byte
//   that completes it is transferred; the compare runs across all window cells
//   in parallel in that same cycle, so no extra stage sits in the path.
// Reset: the window valid bits, the found flag and the result valid flag clear
//   at once; configuration registers return to zero, pattern length to one. No clearing pass.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scan (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wbps_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [wbps_pkg::CfgDataW-1:0] cfg_data_i,
  wbps_in_if.sink                       in_i,
  wbps_out_if.source                    out_o
);

  localparam int unsigned Depth = wbps_pkg::MaxPatternBytes;

  // --------------------------------------------------------------------------
  // Configuration registers. The user must write them only while the scanner is idle; the block does not enforce it.
  // --------------------------------------------------------------------------
  logic [63:0]                   pat_low_q;
  logic [63:0]                   pat_high_q;
  logic [wbps_pkg::CareW-1:0]    care_q;
  logic [wbps_pkg::LenW-1:0]     len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      care_q     <= '0;
      len_q      <= wbps_pkg::LenW'(1);
    end else if (cfg_we_i) begin
      case (wbps_pkg::cfg_reg_e'(cfg_idx_i))
        wbps_pkg::REG_PATTERN_LOW:  pat_low_q  <= cfg_data_i;
        wbps_pkg::REG_PATTERN_HIGH: pat_high_q <= cfg_data_i;
        wbps_pkg::REG_CARE_MASK:    care_q     <= cfg_data_i[wbps_pkg::CareW-1:0];
        wbps_pkg::REG_PATTERN_LEN:  len_q      <= cfg_data_i[wbps_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  // Effective length: zero counts as one, anything past the window depth is
  // clamped to the depth.
  logic [wbps_pkg::LenW-1:0] len_eff;
  logic [wbps_pkg::LenW-1:0] len_m1;

  always_comb begin
    if (len_q == '0) begin
      len_eff = wbps_pkg::LenW'(1);
    end else if (len_q > wbps_pkg::LenW'(Depth)) begin
      len_eff = wbps_pkg::LenW'(Depth);
    end else begin
      len_eff = len_q;
    end
  end

  assign len_m1 = len_eff - wbps_pkg::LenW'(1);

  logic [127:0] pat_all;
  assign pat_all = {pat_high_q, pat_low_q};

  // --------------------------------------------------------------------------
  // Handshake and per-transfer control.
  // A new byte is taken whenever the result slot is empty or being drained,
  // so the scanner never waits on the slot when nothing is pending.
  // --------------------------------------------------------------------------
  logic                       out_vld_q, out_vld_d;
  logic [wbps_pkg::AddrW-1:0] match_addr_q, match_addr_d;
  logic                       found_q, found_d;
  logic                       in_xfer;
  logic                       clear_win;
  logic                       hit;
  wbps_pkg::cell_ctrl_t       ctrl;

  assign in_i.ready = !out_vld_q || out_o.ready;
  assign in_xfer    = in_i.valid && in_i.ready;

  // A new search or a region boundary empties the window before the byte is
  // taken. Once a match has been reported the window takes no new bytes until the
  // next new search.
  assign clear_win  = in_xfer && (in_i.new_search || in_i.region_start);
  assign ctrl.clear = clear_win;
  assign ctrl.shift = in_xfer && (!found_q || in_i.new_search);

  // --------------------------------------------------------------------------
  // Window: a chain of cells, cell k holds the byte seen k transfers ago.
  // Cell k is lined up against signature byte (length - 1 - k).
  // --------------------------------------------------------------------------
  logic [wbps_pkg::ByteW-1:0] win_byte [Depth];
  logic [Depth-1:0]           win_vld;
  logic [Depth-1:0]           vin;
  logic [Depth-1:0]           cell_ok;

  for (genvar k = 0; k < Depth; k++) begin : g_cell
    logic [wbps_pkg::ByteW-1:0] byte_in;
    logic [3:0]                 sig_idx;
    logic                       in_use;

    if (k == 0) begin : g_head
      assign byte_in = in_i.data_byte;
      assign vin[k]  = 1'b1;
    end else begin : g_body
      assign byte_in = win_byte[k-1];
      assign vin[k]  = win_vld[k-1] && !clear_win;
    end

    assign sig_idx = 4'(len_m1 - wbps_pkg::LenW'(k));
    assign in_use  = wbps_pkg::LenW'(k) < len_eff;

    wbps_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .byte_i     (byte_in),
      .valid_i    (vin[k]),
      .pat_byte_i (pat_all[{sig_idx, 3'b000} +: wbps_pkg::ByteW]),
      .care_i     (care_q[sig_idx]),
      .in_use_i   (in_use),
      .byte_o     (win_byte[k]),
      .valid_o    (win_vld[k]),
      .ok_o       (cell_ok[k])
    );
  end

  // A match needs the window to hold at least the pattern length after this
  // byte enters, which is the valid bit arriving at the oldest cell in use.
  assign hit = ctrl.shift && vin[len_m1[wbps_pkg::WinIdxW-1:0]] && (&cell_ok);

  // --------------------------------------------------------------------------
  // Found flag and result slot.
  // --------------------------------------------------------------------------
  always_comb begin
    found_d      = found_q;
    out_vld_d    = out_vld_q;
    match_addr_d = match_addr_q;
    if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
    if (in_xfer && in_i.new_search) begin
      found_d = 1'b0;
    end
    if (hit) begin
      found_d      = 1'b1;
      out_vld_d    = 1'b1;
      match_addr_d = in_i.byte_address - {{(wbps_pkg::AddrW-wbps_pkg::LenW){1'b0}}, len_m1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      found_q   <= found_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    match_addr_q <= match_addr_d;
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.match_address = match_addr_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // The valid bits always fill from the newest cell: no gap in the window.
  a_fill_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((win_vld >> 1) & ~win_vld) == '0)
    else $error("window valid bits are not contiguous");

  // A fresh result only ever follows a byte transfer.
  a_result_from_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !$past(out_o.valid)) |-> $past(in_xfer))
    else $error("result appeared without an input transfer");

  // A match always leaves the found flag set.
  a_hit_sets_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit |=> found_q)
    else $error("found flag not set after a match");

  // After a match the window holds still until a new search or region.
  a_frozen_after_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (found_q && !(in_xfer && (in_i.new_search || in_i.region_start)))
      |=> $stable(win_vld))
    else $error("window moved while a match is held");

  // Input is held back only by an undelivered result.
  a_stall_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (out_vld_q && !out_o.ready))
    else $error("input stalled without a pending result");

endmodule

[tb/wbps_scan_checker.sv]
// ----------------------------------------------------------------------------
// wbps_scan_checker
// Watches the configuration port and both channels of the scanner, predicts
// the start address of each first match and compares every result transfer.
// ----------------------------------------------------------------------------
module wbps_scan_checker
  import wbps_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  wbps_in_if                  in_mon_i,
  wbps_out_if                 out_mon_i,
  output int unsigned         mismatches_o,
  output int unsigned         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Predicted scanner state: slot k holds the byte seen k transfers ago.
  logic [ByteW-1:0]    recent_bytes [MaxPatternBytes];
  int unsigned         bytes_held;
  bit                  search_done;
  logic [CfgDataW-1:0] sig_low;
  logic [CfgDataW-1:0] sig_high;
  logic [CareW-1:0]    care_bits;
  logic [LenW-1:0]     sig_len;

  // Start addresses still owed by the block, oldest first.
  logic [AddrW-1:0]    match_addr_q [$];
  int unsigned         fail_count  = 0;
  int unsigned         outstanding = 0;

  assign mismatches_o = fail_count;
  assign pending_o    = outstanding;

  task automatic report(input string what);
    $display("%0t ns  %s", $time, what);
    fail_count++;
  endtask

  function automatic void clear_window();
    foreach (recent_bytes[k]) recent_bytes[k] = '0;
    bytes_held = 0;
  endfunction

  // A length of zero behaves as one, anything past the window as the window.
  function automatic int unsigned used_len();
    int unsigned n;
    n = 32'(sig_len);
    if (n == 0) n = 1;
    if (n > MaxPatternBytes) n = MaxPatternBytes;
    return n;
  endfunction

  task automatic take_byte(input logic [ByteW-1:0] b, input logic [AddrW-1:0] a,
                           input logic region, input logic fresh);
    int unsigned              n;
    bit                       hit;
    logic [2*CfgDataW-1:0]    sig;
    logic [AddrW-1:0]         start_addr;
    if (fresh) begin
      clear_window();
      search_done = 1'b0;
    end
    if (region) clear_window();
    if (search_done) return;
    for (int k = MaxPatternBytes - 1; k > 0; k--) recent_bytes[k] = recent_bytes[k-1];
    recent_bytes[0] = b;
    if (bytes_held < MaxPatternBytes) bytes_held++;
    n = used_len();
    if (bytes_held < n) return;
    // Signature byte i lines up with the byte that arrived n-1-i transfers ago.
    sig = {sig_high, sig_low};
    hit = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (care_bits[i] && recent_bytes[n-1-i] != sig[8*i +: 8]) hit = 1'b0;
    end
    if (hit) begin
      search_done = 1'b1;
      start_addr  = a - AddrW'(n - 1);
      match_addr_q.push_back(start_addr);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic [AddrW-1:0] want;
    if (!rst_ni) begin
      clear_window();
      search_done = 1'b0;
      sig_low     = '0;
      sig_high    = '0;
      care_bits   = '0;
      sig_len     = LenW'(1);
      match_addr_q.delete();
      outstanding <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PATTERN_LOW:  sig_low   = cfg_data_i;
          REG_PATTERN_HIGH: sig_high  = cfg_data_i;
          REG_CARE_MASK:    care_bits = cfg_data_i[CareW-1:0];
          REG_PATTERN_LEN:  sig_len   = cfg_data_i[LenW-1:0];
          default: ;
        endcase
      end
      // Results are checked before this edge's byte is predicted, so a result
      // can never be matched against the byte transferred at the same edge.
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (match_addr_q.size() == 0) begin
          report($sformatf("result with nothing predicted: match_address %h",
                           out_mon_i.match_address));
        end else begin
          want = match_addr_q.pop_front();
          if (out_mon_i.match_address !== want)
            report($sformatf("match_address %h, predicted %h",
                             out_mon_i.match_address, want));
        end
      end
      if (in_mon_i.valid && in_mon_i.ready)
        take_byte(in_mon_i.data_byte, in_mon_i.byte_address,
                  in_mon_i.region_start, in_mon_i.new_search);
      outstanding <= match_addr_q.size();
    end
  end

endmodule

[tb/wildcard_byte_pattern_scan_test.sv]
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scan_test
// Drives byte streams with planted, broken and absent signatures through the
// scanner under many signature settings, with random idling on both channels
// and one long result stall; a checker beside the block judges every result.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scan_test;
  import wbps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  wbps_in_if  in_ch ();
  wbps_out_if out_ch ();

  int unsigned mismatches;
  int unsigned pending;

  wildcard_byte_pattern_scan dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  wbps_scan_checker match_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_mon_i     (in_ch),
    .out_mon_i    (out_ch),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  // The stimulus keeps its own copy of the signature so that it can plant it.
  logic [CfgDataW-1:0] cur_lo;
  logic [CfgDataW-1:0] cur_hi;
  logic [CareW-1:0]    cur_care;
  logic [LenW-1:0]     cur_len;
  logic [AddrW-1:0]    next_addr;
  int unsigned         items_fed;
  // When calm is set neither side idles. Each bump of hold_reqs asks the
  // result side for one long stall.
  logic                calm;
  int unsigned         hold_reqs;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs on either handshake.
  initial begin
    #3_000_000;
    $display("wildcard_byte_pattern_scan: mismatch");
    $finish;
  end

  // Result side. It takes results at random, except for the long stall, which
  // is counted here so that the byte side keeps offering meanwhile and the
  // block has to fill up and push back.
  initial begin : result_sink
    int unsigned hold_seen;
    int unsigned hold_left;
    hold_seen    = 0;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni) begin
        out_ch.ready <= 1'b0;
      end else if (hold_seen != hold_reqs) begin
        hold_seen     = hold_reqs;
        hold_left     = 80;
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(0, 99) >= 21);
      end
    end
  end

  // Effective signature length, as the block applies it.
  function automatic int unsigned span(input logic [LenW-1:0] len);
    if (len == 0) return 1;
    if (len > MaxPatternBytes) return MaxPatternBytes;
    return 32'(len);
  endfunction

  function automatic logic [ByteW-1:0] signature_byte(input int unsigned i);
    logic [2*CfgDataW-1:0] sig;
    sig = {cur_hi, cur_lo};
    return sig[8*i +: 8];
  endfunction

  // Background bytes: half fully random, half borrowed from the signature so
  // that near misses and accidental partial matches show up.
  function automatic logic [ByteW-1:0] filler();
    if ($urandom_range(0, 1) == 0) return ByteW'($urandom);
    return signature_byte($urandom_range(0, MaxPatternBytes - 1));
  endfunction

  // Region base addresses: zero, just below the top so that a region wraps
  // through zero, or anywhere.
  function automatic logic [AddrW-1:0] pick_address();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return 32'hFFFF_FFF0 + AddrW'($urandom_range(0, 15));
      default: return AddrW'($urandom);
    endcase
  endfunction

  // Offers one byte at next_addr and returns at the edge of its transfer.
  // Valid is left high so that a following byte goes out without a bubble.
  task automatic feed(input logic [ByteW-1:0] b, input logic rs, input logic ns);
    if (!calm) begin
      while ($urandom_range(0, 99) < 21) begin
        in_ch.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_ch.valid        <= 1'b1;
    in_ch.data_byte    <= b;
    in_ch.byte_address <= next_addr;
    in_ch.region_start <= rs;
    in_ch.new_search   <= ns;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    next_addr++;
    items_fed++;
  endtask

  // Waits until every predicted result has been taken, then lets the block run on
  // with no input, since bytes that find nothing leave no trace to wait for.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes all four registers back to back on an idle block.
  task automatic load_signature(input logic [CfgDataW-1:0] lo, input logic [CfgDataW-1:0] hi,
                                input logic [CareW-1:0] care, input logic [LenW-1:0] len);
    settle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_PATTERN_LOW;
    cfg_data_i <= lo;
    @(posedge clk_i);
    cfg_idx_i  <= REG_PATTERN_HIGH;
    cfg_data_i <= hi;
    @(posedge clk_i);
    cfg_idx_i  <= REG_CARE_MASK;
    cfg_data_i <= CfgDataW'(care);
    @(posedge clk_i);
    cfg_idx_i  <= REG_PATTERN_LEN;
    cfg_data_i <= CfgDataW'(len);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cur_lo   = lo;
    cur_hi   = hi;
    cur_care = care;
    cur_len  = len;
  endtask

  initial begin : stimulus
    logic [LenW-1:0]     len;
    logic [CareW-1:0]    care;
    logic [CfgDataW-1:0] lo;
    logic [CfgDataW-1:0] hi;
    logic [ByteW-1:0]    b;
    logic                rs;
    logic                ns;
    logic                jump;
    int unsigned         n;
    int unsigned         stop_at;
    int unsigned         broken_at;
    int unsigned         cut;

    // Every input known from time zero, reset held low.
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = REG_PATTERN_LOW;
    cfg_data_i         = '0;
    in_ch.valid        = 1'b0;
    in_ch.data_byte    = '0;
    in_ch.byte_address = '0;
    in_ch.region_start = 1'b0;
    in_ch.new_search   = 1'b0;
    calm               = 1'b0;
    hold_reqs          = 0;
    items_fed          = 0;
    next_addr          = '0;
    cur_lo             = '0;
    cur_hi             = '0;
    cur_care           = '0;
    cur_len            = LenW'(1);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: length one and no cared bytes, so the very first byte
    // matches. The next byte is ignored because the search is over; the one
    // after carries both flags at the top address and matches again.
    feed(8'h00, 1'b0, 1'b0);
    feed(8'hFF, 1'b0, 1'b0);
    next_addr = 32'hFFFF_FFFF;
    feed(8'hFF, 1'b1, 1'b1);

    // Four bytes with a wildcard in the last position, and care bits set past
    // the length whose signature bytes would never match. The stream starts
    // two bytes below the top, so the reported start address lies before the
    // wrap while the completing byte lies after it.
    load_signature(64'h0102_0304_44C3_A51E, 64'hFFEE_DDCC_BBAA_9988, 16'hFFF7, 5'd4);
    next_addr = 32'hFFFF_FFFE;
    feed(8'h1E, 1'b0, 1'b1);
    feed(8'hA5, 1'b0, 1'b0);
    feed(8'hC3, 1'b0, 1'b0);
    feed(8'h00, 1'b0, 1'b0);
    // A signature split by a region start must not match; the window is then
    // refilled in the new region and the match starts on its third byte.
    next_addr = 32'h0000_0100;
    feed(8'h1E, 1'b0, 1'b1);
    feed(8'hA5, 1'b0, 1'b0);
    next_addr = 32'h0000_0200;
    feed(8'hC3, 1'b1, 1'b0);
    feed(8'h55, 1'b0, 1'b0);
    feed(8'h1E, 1'b0, 1'b0);
    feed(8'hA5, 1'b0, 1'b0);
    feed(8'hC3, 1'b0, 1'b0);
    feed(8'hFF, 1'b0, 1'b0);

    // A length of zero acts as one; every bit cared, only byte zero counts.
    load_signature(64'hFFFF_FFFF_FFFF_FFAB, '1, 16'hFFFF, 5'd0);
    feed(8'h00, 1'b0, 1'b1);
    feed(8'hAB, 1'b0, 1'b0);

    // Random phases. The first few pin the length extremes, including values
    // outside the usable range. Each phase runs about 110 bytes.
    for (int ph = 0; ph < 13; ph++) begin
      calm <= (ph == 6 || ph == 7);
      case (ph)
        0:       len = 5'd16;
        1:       len = 5'd1;
        2:       len = 5'd0;
        3:       len = 5'd31;
        default: len = ($urandom_range(0, 9) == 0) ? LenW'($urandom_range(17, 31))
                                                   : LenW'($urandom_range(1, 16));
      endcase
      case ($urandom_range(0, 4))
        0:       care = '0;
        1:       care = '1;
        2:       care = CareW'($urandom) & ~(CareW'(1) << (span(len) - 1));
        default: care = CareW'($urandom);
      endcase
      case ($urandom_range(0, 5))
        0: begin
          lo = '0;
          hi = '0;
        end
        1: begin
          lo = '1;
          hi = '1;
        end
        default: begin
          lo = {$urandom, $urandom};
          hi = {$urandom, $urandom};
        end
      endcase
      load_signature(lo, hi, care, len);

      stop_at = items_fed + 110;
      while (items_fed < stop_at) begin
        if ($urandom_range(0, 99) < 70) begin
          // A proper search: fresh start, some background, the signature with
          // random bytes in its wildcard slots, then bytes the block ignores.
          // Now and then one signature byte is corrupted, or a region start cuts
          // in; a cut at the first signature byte still lets it match.
          n    = span(cur_len);
          jump = ($urandom_range(0, 1) == 1);
          if (jump) next_addr = pick_address();
          feed(filler(), jump, 1'b1);
          repeat ($urandom_range(0, 5)) feed(filler(), 1'b0, 1'b0);
          broken_at = ($urandom_range(0, 6) == 0) ? $urandom_range(0, n - 1) : n;
          cut       = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n - 1) : n;
          for (int i = 0; i < n; i++) begin
            b = cur_care[i] ? signature_byte(i) : ByteW'($urandom);
            if (i == broken_at) b = b ^ ByteW'($urandom_range(1, 255));
            if (i == cut) next_addr = pick_address();
            feed(b, i == cut, 1'b0);
          end
          repeat ($urandom_range(0, 3)) feed(filler(), 1'b0, 1'b0);
        end else begin
          // Loose traffic with the flags at random.
          repeat ($urandom_range(1, 8)) begin
            rs = ($urandom_range(0, 9) == 0);
            ns = ($urandom_range(0, 19) == 0);
            if (rs) next_addr = pick_address();
            feed(filler(), rs, ns);
          end
        end
      end

      // Back pressure: with length one and nothing cared, every byte that
      // starts a search is a match, so the results pile up while the result
      // side stalls and the block must hold off its byte input.
      if (ph == 4) begin
        load_signature({$urandom, $urandom}, {$urandom, $urandom}, '0, 5'd1);
        hold_reqs <= hold_reqs + 1;
        repeat (40) feed(ByteW'($urandom), 1'b0, 1'b1);
      end
    end

    calm <= 1'b0;
    settle();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("wildcard_byte_pattern_scan: match");
    end else begin
      $display("wildcard_byte_pattern_scan: mismatch");
    end
    $finish;
  end

endmodule
